### hdl/irpw_pkg.sv
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants of the IR pulse width capture block.
// ----------------------------------------------------------------------------
package irpw_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_DUMP = 2'd2;

  // outcome codes of a result item
  localparam logic [2:0] OUT_STORED    = 3'd0;
  localparam logic [2:0] OUT_BOUNCE    = 3'd1;
  localparam logic [2:0] OUT_BACKWARDS = 3'd2;
  localparam logic [2:0] OUT_LONG_GAP  = 3'd3;
  localparam logic [2:0] OUT_READ      = 3'd4;
  localparam logic [2:0] OUT_STATUS    = 3'd5;

  // configuration register indexes
  localparam logic CFG_MIN_WIDTH = 1'b0;
  localparam logic CFG_MAX_GAP   = 1'b1;

  // configuration reset values
  localparam logic [19:0] MIN_WIDTH_RST = 20'd20;
  localparam logic [7:0]  MAX_GAP_RST   = 8'd15;

  // time and width constants
  localparam int unsigned USEC_PER_SEC = 1000000;
  localparam logic [23:0] WIDTH_MAX    = 24'hFFFFFF;

  // read index scaling for the slot reduction
  localparam int unsigned RECIP_SHIFT = 20;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // item kind after classification
  typedef enum logic [1:0] {
    KIND_EDGE,
    KIND_READ,
    KIND_DUMP
  } item_kind_t;

  // classified item handed from front to back
  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] sec;
    logic [19:0] usec;
    logic        level;
    logic [9:0]  slot;
    logic        keep;
  } queue_item_t;

  // configuration write
  typedef struct packed {
    logic        valid;
    logic        index;
    logic [19:0] data;
  } cfg_wr_t;

endpackage

### hdl/irpw_front.sv
// ----------------------------------------------------------------------------
// irpw_front
// Accepts input items, decodes the operation and reduces the read index to a
// store slot, then hands the classified item to the queue.
// ----------------------------------------------------------------------------
module irpw_front #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [31:0]          time_sec,
  input  logic [19:0]          time_usec,
  input  logic                 line_level,
  input  logic [9:0]           read_index,
  input  logic                 keep_count,
  input  logic                 q_full,
  output logic                 push,
  output irpw_pkg::queue_item_t push_item
);
  import irpw_pkg::*;

  localparam int unsigned RECIP = (1 << RECIP_SHIFT) / STORE_DEPTH;

  logic        s1_valid;
  item_kind_t  s1_kind;
  logic [31:0] s1_sec;
  logic [19:0] s1_usec;
  logic        s1_level;
  logic        s1_keep;
  logic [9:0]  s1_ridx;
  logic [9:0]  s1_quot;

  logic        accept;
  logic        known_op;
  item_kind_t  kind_dec;
  logic [29:0] quot_prod;
  logic [27:0] quot_back;
  logic [10:0] rem;
  logic [9:0]  slot;

  // operation decode, unused code is taken and dropped
  always_comb begin
    known_op = 1'b1;
    kind_dec = KIND_EDGE;
    unique case (operation)
      OP_EDGE: kind_dec = KIND_EDGE;
      OP_READ: kind_dec = KIND_READ;
      OP_DUMP: kind_dec = KIND_DUMP;
      default: known_op = 1'b0;
    endcase
  end

  assign in_stall  = s1_valid && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = s1_valid && !q_full;

  // quotient estimate by reciprocal, at most one below the true quotient
  assign quot_prod = 30'(read_index) * 30'(RECIP);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= known_op;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_kind  <= kind_dec;
      s1_sec   <= time_sec;
      s1_usec  <= time_usec;
      s1_level <= line_level;
      s1_keep  <= keep_count;
      s1_ridx  <= read_index;
      s1_quot  <= quot_prod[29:20];
    end
  end

  // remainder with one correction step
  always_comb begin
    quot_back = 28'(s1_quot) * 28'(STORE_DEPTH);
    rem       = {1'b0, s1_ridx} - quot_back[10:0];
    if (32'(rem) >= 32'(STORE_DEPTH)) begin
      slot = rem[9:0] - 10'(STORE_DEPTH);
    end else begin
      slot = rem[9:0];
    end
  end

  always_comb begin
    push_item.kind  = s1_kind;
    push_item.sec   = s1_sec;
    push_item.usec  = s1_usec;
    push_item.level = s1_level;
    push_item.slot  = slot;
    push_item.keep  = s1_keep;
  end

endmodule

### hdl/irpw_queue.sv
// ----------------------------------------------------------------------------
// irpw_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module irpw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  irpw_pkg::queue_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output irpw_pkg::queue_item_t head_item
);
  import irpw_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  queue_item_t       slots [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     fill;

  assign full       = (fill == CW'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### hdl/irpw_back.sv
// ----------------------------------------------------------------------------
// irpw_back
// Carries out classified items: edge timing, width store, reads and dumps,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module irpw_back #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  irpw_pkg::cfg_wr_t     cfg_wr,
  input  logic                 q_valid,
  input  irpw_pkg::queue_item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           outcome,
  output logic [23:0]          width_us,
  output logic                 entry_level,
  output logic [9:0]           entry_index,
  output logic                 echo_level,
  output logic [10:0]          status_count
);
  import irpw_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  // configuration
  logic [19:0] min_width;
  logic [7:0]  max_gap;

  // block state
  logic [31:0]   last_sec;
  logic [19:0]   last_usec;
  logic [CW-1:0] cnt;
  logic [CW-1:0] hwm;
  logic          echo;

  // width and level store, written entries always form a prefix below hwm
  logic [24:0]   store [STORE_DEPTH];
  logic [24:0]   rd_data;
  logic          wr_en;
  logic          rd_en;

  // output register
  logic [2:0]  o_outcome;
  logic [23:0] o_width;
  logic        o_level;
  logic [9:0]  o_index;
  logic        o_echo;
  logic [10:0] o_status;
  logic        o_hit;

  // edge evaluation
  logic               ts_back;
  logic [31:0]        dsec;
  logic               is_gap;
  logic [7:0]         dsec_lo;
  logic [27:0]        span_us;
  logic signed [29:0] wsum;
  logic               is_bounce;
  logic [23:0]        wsat;
  logic               cnt_full;
  logic [CW-1:0]      wslot;
  logic [CW-1:0]      cnt_inc;
  logic               rd_hit;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    ts_back   = ({q_item.sec, q_item.usec} < {last_sec, last_usec});
    dsec      = q_item.sec - last_sec;
    is_gap    = (dsec > 32'(max_gap));
    // low byte is enough for the width once the gap check passes
    dsec_lo   = q_item.sec[7:0] - last_sec[7:0];
    span_us   = 28'(dsec_lo) * 28'(USEC_PER_SEC);
    wsum      = $signed({2'b00, span_us}) + $signed(30'(q_item.usec))
                - $signed(30'(last_usec));
    is_bounce = (wsum < $signed(30'(min_width)));
    wsat      = (wsum > $signed(30'(WIDTH_MAX))) ? WIDTH_MAX : wsum[23:0];
    cnt_full  = (cnt >= CW'(STORE_DEPTH));
    wslot     = cnt_full ? '0 : cnt;
    cnt_inc   = wslot + 1'b1;
    rd_hit    = (32'(q_item.slot) < 32'(hwm));
  end

  assign wr_en = pop && (q_item.kind == KIND_EDGE) && !ts_back && !is_gap && !is_bounce;
  assign rd_en = pop && (q_item.kind == KIND_READ);

  // store access, read data held while the output is stalled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[AW'(wslot)] <= {wsat, !q_item.level};
    end
    if (rd_en) begin
      rd_data <= store[AW'(q_item.slot)];
    end
  end

  // configuration, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= MIN_WIDTH_RST;
      max_gap   <= MAX_GAP_RST;
      last_sec  <= '0;
      last_usec <= '0;
      cnt       <= '0;
      hwm       <= '0;
      echo      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          CFG_MIN_WIDTH: min_width <= cfg_wr.data;
          CFG_MAX_GAP:   max_gap   <= cfg_wr.data[7:0];
        endcase
      end
      if (pop) begin
        out_valid <= 1'b1;
        o_width   <= '0;
        o_level   <= 1'b0;
        o_index   <= '0;
        o_hit     <= 1'b0;
        o_echo    <= echo;
        o_status  <= 11'(cnt);
        unique case (q_item.kind)
          KIND_EDGE: begin
            priority if (ts_back) begin
              o_outcome <= OUT_BACKWARDS;
              last_sec  <= q_item.sec;
              last_usec <= q_item.usec;
            end else if (is_gap) begin
              o_outcome <= OUT_LONG_GAP;
              last_sec  <= q_item.sec;
              last_usec <= q_item.usec;
            end else if (is_bounce) begin
              o_outcome <= OUT_BOUNCE;
            end else begin
              o_outcome <= OUT_STORED;
              o_width   <= wsat;
              o_level   <= !q_item.level;
              o_index   <= 10'(wslot);
              o_echo    <= q_item.level;
              o_status  <= 11'(cnt_inc);
              echo      <= q_item.level;
              cnt       <= cnt_inc;
              last_sec  <= q_item.sec;
              last_usec <= q_item.usec;
              if (cnt_inc > hwm) begin
                hwm <= cnt_inc;
              end
            end
          end
          KIND_READ: begin
            o_outcome <= OUT_READ;
            o_index   <= q_item.slot;
            o_hit     <= rd_hit;
          end
          KIND_DUMP: begin
            o_outcome <= OUT_STATUS;
            if (!q_item.keep) begin
              cnt      <= '0;
              o_status <= '0;
            end
          end
          default: o_outcome <= OUT_STATUS;
        endcase
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result fields, read data comes straight from the store register
  always_comb begin
    outcome      = o_outcome;
    entry_index  = o_index;
    echo_level   = o_echo;
    status_count = o_status;
    if (o_outcome == OUT_READ) begin
      width_us    = o_hit ? rd_data[24:1] : '0;
      entry_level = o_hit ? rd_data[0] : 1'b0;
    end else begin
      width_us    = o_width;
      entry_level = o_level;
    end
  end

endmodule

### hdl/ir_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_capture
// Records IR pulse and space widths from timestamped edge items into a
// circular store, with entry read back and a count dump command.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) takes one item per cycle unless
//   stalled: an edge, an entry read or a dump; operation code 3 is taken and
//   gives no result. output channel (out_valid / out_stall) gives one result
//   per other item, in order. configuration writes (cfg_valid / cfg_ready,
//   always ready) set the bounce limit (index 0) and the idle gap limit
//   (index 1); the user must keep to idle, the block does not enforce it.
// timing
//   in order: input register, two entry queue, execute stage, output register.
//   throughput is one item per cycle unless the output stalls; edge timing
//   and the store write happen together, so back to back edges do not wait.
// reset
//   synchronous; clears time, count, echo pin and config to defaults. the
//   store needs no clearing pass: entries above the written mark read as 0.
// stall
//   a stalled output holds; the queue and input register absorb up to three
//   more items, then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module ir_pulse_width_capture #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] time_sec,
  input  logic [19:0] time_usec,
  input  logic        line_level,
  input  logic [9:0]  read_index,
  input  logic        keep_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  outcome,
  output logic [23:0] width_us,
  output logic        entry_level,
  output logic [9:0]  entry_index,
  output logic        echo_level,
  output logic [10:0] status_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);
  import irpw_pkg::*;

  logic        q_full;
  logic        push;
  queue_item_t push_item;
  logic        pop;
  logic        q_valid;
  queue_item_t q_item;
  cfg_wr_t     cfg_wr;

  // configuration port
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // accept and classify
  irpw_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .time_sec   (time_sec),
    .time_usec  (time_usec),
    .line_level (line_level),
    .read_index (read_index),
    .keep_count (keep_count),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  // decoupling queue
  irpw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  // execute and result
  irpw_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr       (cfg_wr),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .outcome      (outcome),
    .width_us     (width_us),
    .entry_level  (entry_level),
    .entry_index  (entry_index),
    .echo_level   (echo_level),
    .status_count (status_count)
  );

endmodule

### hdl/irpw_checker.sv
// ----------------------------------------------------------------------------
// irpw_checker
// Port level checks of the IR pulse width capture block.
// ----------------------------------------------------------------------------
module irpw_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  outcome,
  input logic [23:0] width_us,
  input logic        entry_level,
  input logic [9:0]  entry_index,
  input logic        echo_level,
  input logic [10:0] status_count
);
  import irpw_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(width_us)
      && $stable(entry_index) && $stable(status_count))
    else $error("stalled result changed");

  // results without an entry carry zero entry fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_BOUNCE || outcome == OUT_BACKWARDS
      || outcome == OUT_LONG_GAP || outcome == OUT_STATUS)
    |-> width_us == '0 && !entry_level && entry_index == '0)
    else $error("unused result fields not zero");

  // a stored edge echoes the line level, the store keeps its inverse
  a_store_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_STORED |-> echo_level == !entry_level)
    else $error("echo level does not match stored level");

  // count follows the slot just written
  a_store_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_STORED |-> status_count[9:0] == entry_index + 10'd1)
    else $error("entry count does not follow written slot");

endmodule

bind ir_pulse_width_capture irpw_checker u_irpw_checker (.*);
